FILE: rtl/sensor_frame_sync_checksum_core_macros.svh
// assertion macros for the sensor frame sync checksum core
// expects clk and rst_n in the scope of each use
`ifndef SENSOR_FRAME_SYNC_CHECKSUM_CORE_MACROS_SVH
`define SENSOR_FRAME_SYNC_CHECKSUM_CORE_MACROS_SVH

// same-cycle implication, disabled during reset
`define SFSC_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled during reset
`define SFSC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/sfsc_pkg.sv
// shared types and constants for the sensor frame sync checksum core
// no dependencies
`timescale 1ns / 1ps

package sfsc_pkg;

  localparam int STORE_DEPTH_DEF = 16;

  localparam logic [7:0] HEADER_BYTE = 8'h5A;
  localparam logic [3:0] LIGHT_LEN   = 4'd9;
  localparam logic [3:0] FULL_LEN    = 4'd15;

  // controller to datapath
  typedef struct packed {
    logic keep;
    logic restart;
    logic capture;
    logic advance;
    logic load_out;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic cnt_zero;
    logic cnt_one;
    logic cnt_ge_len;
    logic cnt_mid;
    logic is_header;
    logic sum_match;
    logic emit_last;
    logic out_free;
  } status_t;

endpackage

FILE: rtl/sfsc_datapath.sv
// frame store, byte counter, running sum and output register
// depends on sfsc_pkg
`timescale 1ns / 1ps

module sfsc_datapath #(
  parameter int STORE_DEPTH = sfsc_pkg::STORE_DEPTH_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic [7:0]        in_byte,
  input  logic              cfg_we,
  input  logic              cfg_mode,
  input  logic              out_tready,
  input  sfsc_pkg::cmd_t    cmd,
  output sfsc_pkg::status_t status,
  output logic              out_tvalid,
  output logic [15:0]       out_tdata, // frame_byte[7:0], byte_index[11:8], zero[15:12]
  output logic              out_tlast  // last_byte
);

  localparam int IDX_W = $clog2(STORE_DEPTH);

  logic [7:0] mem [STORE_DEPTH];
  logic [7:0] rd_data_r;

  logic       mode_r;
  logic [3:0] cnt_r, cnt_nxt;
  logic [7:0] sum_r, sum_nxt;
  logic [3:0] emit_idx_r, emit_idx_nxt;
  logic [3:0] last_idx_r;
  logic       out_valid_r;
  logic [7:0] out_byte_r;
  logic [3:0] out_idx_r;
  logic       out_last_r;
  logic [3:0] len;

  assign len = mode_r ? sfsc_pkg::FULL_LEN : sfsc_pkg::LIGHT_LEN;

  assign status.cnt_zero   = (cnt_r == 4'd0);
  assign status.cnt_one    = (cnt_r == 4'd1);
  assign status.cnt_ge_len = (cnt_r >= len);
  assign status.cnt_mid    = (({1'b0, cnt_r} + 5'd1) < {1'b0, len});
  assign status.is_header  = (in_byte == sfsc_pkg::HEADER_BYTE);
  assign status.sum_match  = (in_byte == sum_r);
  assign status.emit_last  = (emit_idx_r == last_idx_r);
  assign status.out_free   = !out_valid_r || out_tready;

  always_comb begin
    cnt_nxt = cnt_r;
    sum_nxt = sum_r;
    if (cmd.restart || cmd.capture) begin
      cnt_nxt = 4'd0;
      sum_nxt = 8'd0;
    end else if (cmd.keep) begin
      cnt_nxt = cnt_r + 4'd1;
      sum_nxt = sum_r + in_byte;
    end
  end

  always_comb begin
    emit_idx_nxt = emit_idx_r;
    if (cmd.capture) begin
      emit_idx_nxt = 4'd0;
    end else if (cmd.advance) begin
      emit_idx_nxt = emit_idx_r + 4'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r      <= 1'b0;
      cnt_r       <= 4'd0;
      sum_r       <= 8'd0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        mode_r <= cfg_mode;
      end
      cnt_r <= cnt_nxt;
      sum_r <= sum_nxt;
      if (cmd.load_out) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    emit_idx_r <= emit_idx_nxt;
    if (cmd.capture) begin
      last_idx_r <= len - 4'd1;
    end
    if (cmd.load_out) begin
      out_byte_r <= rd_data_r;
      out_idx_r  <= emit_idx_r;
      out_last_r <= status.emit_last;
    end
  end

  // frame store, one write and one registered read per cycle
  always_ff @(posedge clk) begin
    if (cmd.keep || cmd.capture) begin
      mem[IDX_W'(cnt_r)] <= in_byte;
    end
    rd_data_r <= mem[IDX_W'(emit_idx_r)];
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {4'd0, out_idx_r, out_byte_r};
  assign out_tlast  = out_last_r;

endmodule

FILE: rtl/sfsc_ctrl.sv
// controller: header hunt, checksum decision and frame replay sequencing
// depends on sfsc_pkg
`timescale 1ns / 1ps

module sfsc_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  input  sfsc_pkg::status_t status,
  output sfsc_pkg::cmd_t    cmd
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_READ = 2'd1;
  localparam logic [1:0] ST_LOAD = 2'd2;

  logic [1:0] state_r, state_nxt;

  assign in_tready = (state_r == ST_IDLE);

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_tvalid) begin
          if (status.cnt_zero) begin
            cmd.keep = status.is_header;
          end else if (status.cnt_one) begin
            cmd.keep    = status.is_header;
            cmd.restart = !status.is_header;
          end else if (status.cnt_ge_len) begin
            cmd.restart = 1'b1;
          end else if (status.cnt_mid) begin
            cmd.keep = 1'b1;
          end else if (status.sum_match) begin
            cmd.capture = 1'b1;
            state_nxt   = ST_READ;
          end else begin
            cmd.restart = 1'b1;
          end
        end
      end
      ST_READ: begin
        state_nxt = ST_LOAD;
      end
      ST_LOAD: begin
        if (status.out_free) begin
          cmd.load_out = 1'b1;
          if (status.emit_last) begin
            state_nxt = ST_IDLE;
          end else begin
            cmd.advance = 1'b1;
            state_nxt   = ST_READ;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

FILE: rtl/sensor_frame_sync_checksum_core.sv
// Sensor frame sync and checksum core, top level.
// Depends on sfsc_pkg, sfsc_ctrl and sfsc_datapath.
//
// Usage:
//   in_*  : one received serial byte per transaction in in_tdata.
//   out_* : bytes of a validated frame, one per transaction, tlast on the
//           check byte; byte position in out_tdata[11:8].
//   cfg_* : frame_mode write, 0 for the 9-byte frame, 1 for the 15-byte one;
//           cfg_ready is always high.
// Throughput: while a frame is being collected a byte is taken every cycle.
// Once the check byte matches, the frame is replayed from the store; each
// byte goes through a registered store read, then an output load, and no
// input is taken until the frame's final byte is loaded into the output
// register.
// After the check byte: READ state, LOAD state, then the output register.
// Stall: with out_tready low the output holds and the replay waits.
// Reset: synchronous, clears counter, sum, mode and output valid; the store
// itself is not cleared.
`timescale 1ns / 1ps

module sensor_frame_sync_checksum_core #(
  parameter int STORE_DEPTH = sfsc_pkg::STORE_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // rx_byte[7:0]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,  // frame_byte[7:0], byte_index[11:8], zero[15:12]
  output logic        out_tlast,  // last_byte
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_data    // frame_mode
);

  sfsc_pkg::cmd_t    cmd;
  sfsc_pkg::status_t status;

  assign cfg_ready = 1'b1;

  sfsc_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .status    (status),
    .cmd       (cmd)
  );

  sfsc_datapath #(
    .STORE_DEPTH (STORE_DEPTH)
  ) u_datapath (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_byte    (in_tdata),
    .cfg_we     (cfg_valid && cfg_ready),
    .cfg_mode   (cfg_data),
    .out_tready (out_tready),
    .cmd        (cmd),
    .status     (status),
    .out_tvalid (out_tvalid),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

endmodule

FILE: rtl/sfsc_checker.sv
// port-level checks for the sensor frame sync checksum core, bound to the top
// depends on sensor_frame_sync_checksum_core_macros.svh
`timescale 1ns / 1ps
`include "sensor_frame_sync_checksum_core_macros.svh"

module sfsc_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [15:0] out_tdata,
  input logic        out_tlast
);

  `SFSC_ASSERT_NEXT(a_out_hold, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata) && $stable(out_tlast), "output changed while stalled")

  `SFSC_ASSERT_IMPL(a_no_input_mid_frame, out_tvalid && !out_tlast, !in_tready, "input taken during frame replay")

  `SFSC_ASSERT_IMPL(a_last_index, out_tvalid && out_tlast, (out_tdata[11:8] == 4'd8) || (out_tdata[11:8] == 4'd14), "last byte at wrong position")

  `SFSC_ASSERT_NEXT(a_index_step, out_tvalid && out_tready && !out_tlast, !out_tvalid || (out_tdata[11:8] == $past(out_tdata[11:8]) + 4'd1), "frame byte index skipped")

endmodule

bind sensor_frame_sync_checksum_core sfsc_checker u_sfsc_checker (.*);

FILE: tb/tb_sensor_frame_sync_checksum_core.sv
// self-checking testbench for sensor_frame_sync_checksum_core: header hunt, checksum and replay
// depends on sfsc_pkg and the core; a scoreboard of expected frame bytes is checked at the output
`timescale 1ns / 1ps

module tb_sensor_frame_sync_checksum_core;

  localparam logic MODE_LIGHT = 1'b0;
  localparam logic MODE_FULL  = 1'b1;
  localparam int SETTLE_CYCLES = 40;
  localparam int RANDOM_BYTES  = 120;
  localparam int REPORT_CAP    = 200;

  typedef enum logic [1:0] {
    RX_OPEN,
    RX_RANDOM,
    RX_PERIODIC
  } rx_style_t;

  typedef struct packed {
    logic [7:0] fbyte;
    logic [3:0] idx;
    logic       last;
  } frame_beat_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata = 8'h00;   // rx_byte[7:0]
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [15:0] out_tdata;          // frame_byte[7:0], byte_index[11:8], zero[15:12]
  logic        out_tlast;          // last_byte
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic        cfg_data = 1'b0;    // frame_mode

  // parser shadow state
  logic [7:0]  frame_shadow [16];
  logic [3:0]  count_shadow = 4'd0;
  logic [7:0]  sum_shadow = 8'd0;
  logic        mode_shadow = MODE_LIGHT;

  frame_beat_t beats_q [$];
  logic [7:0]  pend_q [$];
  int          items_pushed = 0;
  int          items_taken = 0;
  int          errors = 0;
  int          gap_left = 0;
  int          burst_left = 0;
  bit          tx_bursty = 1'b0;
  rx_style_t   rx_style = RX_OPEN;
  int          rx_tick = 0;

  sensor_frame_sync_checksum_core uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data)
  );

  always #10 clk = ~clk;

  function automatic void keep_byte(input logic [7:0] b);
    frame_shadow[count_shadow] = b;
    sum_shadow = sum_shadow + b;
    count_shadow = count_shadow + 4'd1;
  endfunction

  // expected frame bytes caused by one received byte
  function automatic void parse_byte(input logic [7:0] b);
    frame_beat_t beat;
    int          flen;
    flen = (mode_shadow == MODE_FULL) ? int'(sfsc_pkg::FULL_LEN) : int'(sfsc_pkg::LIGHT_LEN);
    if (count_shadow == 4'd0) begin
      if (b == sfsc_pkg::HEADER_BYTE) keep_byte(b);
    end else if (count_shadow == 4'd1) begin
      if (b == sfsc_pkg::HEADER_BYTE) begin
        keep_byte(b);
      end else begin
        count_shadow = 4'd0;
        sum_shadow = 8'd0;
      end
    end else if (int'(count_shadow) >= flen) begin
      count_shadow = 4'd0;
      sum_shadow = 8'd0;
    end else if (int'(count_shadow) + 1 < flen) begin
      keep_byte(b);
    end else begin
      if (b == sum_shadow) begin
        for (int i = 0; i < flen - 1; i++) begin
          beat.fbyte = frame_shadow[i];
          beat.idx = i[3:0];
          beat.last = 1'b0;
          beats_q.push_back(beat);
        end
        beat.fbyte = b;
        beat.idx = flen[3:0] - 4'd1;
        beat.last = 1'b1;
        beats_q.push_back(beat);
      end
      count_shadow = 4'd0;
      sum_shadow = 8'd0;
    end
  endfunction

  // sender: back-to-back, or bursts with random gaps when tx_bursty is set
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else if (!in_tvalid || in_tready) begin
      if (gap_left > 0 || pend_q.size() == 0) begin
        in_tvalid <= 1'b0;
        if (gap_left > 0) gap_left--;
      end else begin
        in_tvalid <= 1'b1;
        in_tdata <= pend_q.pop_front();
        if (burst_left > 0) begin
          burst_left--;
        end else if (tx_bursty) begin
          burst_left = $urandom_range(0, 11);
          gap_left = $urandom_range(1, 8);
        end
      end
    end
  end

  // receiver back-pressure
  always @(posedge clk) begin
    rx_tick <= rx_tick + 1;
    case (rx_style)
      RX_OPEN: begin
        out_tready <= 1'b1;
      end
      RX_RANDOM: begin
        out_tready <= ($urandom_range(0, 3) != 0);
      end
      default: begin
        out_tready <= ((rx_tick % 9) >= 4);
      end
    endcase
  end

  // monitor and scoreboard
  always @(posedge clk) begin : mon
    frame_beat_t want;
    if (rst_n) begin
      if (cfg_valid && cfg_ready) mode_shadow = cfg_data;
      if (in_tvalid && in_tready) begin
        items_taken++;
        parse_byte(in_tdata);
      end
      if (out_tvalid && out_tready) begin
        if (beats_q.size() == 0) begin
          errors++;
          if (errors < REPORT_CAP)
            $display("%0t: unexpected transaction, expected none, actual %04h last %0b",
                     $time, out_tdata, out_tlast);
        end else begin
          want = beats_q.pop_front();
          if (out_tdata[7:0] !== want.fbyte) begin
            errors++;
            if (errors < REPORT_CAP)
              $display("%0t: frame_byte mismatch, expected %02h, actual %02h",
                       $time, want.fbyte, out_tdata[7:0]);
          end
          if (out_tdata[11:8] !== want.idx) begin
            errors++;
            if (errors < REPORT_CAP)
              $display("%0t: byte_index mismatch, expected %0d, actual %0d",
                       $time, want.idx, out_tdata[11:8]);
          end
          if (out_tdata[15:12] !== 4'h0) begin
            errors++;
            if (errors < REPORT_CAP)
              $display("%0t: padding mismatch, expected 0, actual %0h",
                       $time, out_tdata[15:12]);
          end
          if (out_tlast !== want.last) begin
            errors++;
            if (errors < REPORT_CAP)
              $display("%0t: last_byte mismatch, expected %0b, actual %0b",
                       $time, want.last, out_tlast);
          end
        end
      end
    end
  end

  task automatic push_byte(input logic [7:0] b);
    pend_q.push_back(b);
    items_pushed++;
  endtask

  // sends the bytes, then a check byte that is right or deliberately wrong
  task automatic send_frame(input logic [7:0] body [$], input bit good);
    logic [7:0] sum;
    sum = 8'd0;
    foreach (body[i]) begin
      push_byte(body[i]);
      sum = sum + body[i];
    end
    push_byte(good ? sum : sum ^ 8'($urandom_range(1, 255)));
  endtask

  task automatic random_frame(input int flen, input bit good);
    logic [7:0] body [$];
    body.push_back(sfsc_pkg::HEADER_BYTE);
    body.push_back(sfsc_pkg::HEADER_BYTE);
    for (int i = 2; i < flen - 1; i++) body.push_back(8'($urandom_range(0, 255)));
    send_frame(body, good);
  endtask

  task automatic wait_idle();
    @(negedge clk);
    while (!(items_taken == items_pushed && beats_q.size() == 0)) @(negedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_mode(input logic m);
    @(posedge clk);
    cfg_data <= m;
    cfg_valid <= 1'b1;
    @(negedge clk);
    while (!cfg_ready) @(negedge clk);
    @(posedge clk);
    cfg_valid <= 1'b0;
  endtask

  initial begin
    logic [7:0] body [$];
    logic [7:0] b;
    logic [7:0] sum;
    logic       mode;
    int         random_bytes;
    int         phase_bytes;
    int         flen;
    int         pick;
    int         ph;

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    write_mode(MODE_LIGHT);

    // bad first header, bad second header, then a light frame with extreme data
    tx_bursty = 1'b1;
    rx_style = RX_RANDOM;
    push_byte(8'h00);
    push_byte(sfsc_pkg::HEADER_BYTE);
    push_byte(8'hA5);
    body = '{sfsc_pkg::HEADER_BYTE, sfsc_pkg::HEADER_BYTE, 8'hFF, 8'h00, 8'h80, 8'h7F,
             8'h01, 8'hFE};
    send_frame(body, 1'b1);
    wait_idle();

    // frame grows from light to full length part way through collection
    body = '{sfsc_pkg::HEADER_BYTE, sfsc_pkg::HEADER_BYTE, 8'h11, 8'h22, 8'h33, 8'hC3,
             8'h3C, 8'hAA, 8'h55, 8'h0F, 8'hF0, 8'hE7, 8'h18, 8'h96};
    sum = 8'd0;
    foreach (body[i]) sum = sum + body[i];
    for (int i = 0; i < 5; i++) push_byte(body[i]);
    wait_idle();
    write_mode(MODE_FULL);
    for (int i = 5; i < 14; i++) push_byte(body[i]);
    push_byte(sum);
    wait_idle();

    // random phases, mode alternating so that a change can land on a partial frame
    random_bytes = 0;
    ph = 0;
    mode = MODE_FULL;
    while (random_bytes < RANDOM_BYTES) begin
      mode = ~mode;
      write_mode(mode);
      tx_bursty = (ph != 0) && ($urandom_range(0, 3) != 0);
      rx_style = (ph == 0) ? RX_OPEN : rx_style_t'($urandom_range(0, 2));
      phase_bytes = 0;
      while (phase_bytes < 35) begin
        pick = $urandom_range(0, 99);
        flen = (mode == MODE_FULL) ? int'(sfsc_pkg::FULL_LEN) : int'(sfsc_pkg::LIGHT_LEN);
        if (pick < 60) begin
          random_frame(flen, 1'b1);
          phase_bytes += flen;
        end else if (pick < 72) begin
          random_frame(flen, 1'b0);
          phase_bytes += flen;
        end else if (pick < 80) begin
          flen = (mode == MODE_FULL) ? int'(sfsc_pkg::LIGHT_LEN) : int'(sfsc_pkg::FULL_LEN);
          random_frame(flen, 1'b1);
          phase_bytes += flen;
        end else if (pick < 90) begin
          b = 8'($urandom_range(0, 255));
          if (b == sfsc_pkg::HEADER_BYTE) b = b ^ 8'h01;
          push_byte(sfsc_pkg::HEADER_BYTE);
          push_byte(b);
          phase_bytes += 2;
        end else begin
          repeat ($urandom_range(1, 4)) begin
            b = ($urandom_range(0, 3) == 0) ? sfsc_pkg::HEADER_BYTE
                                            : 8'($urandom_range(0, 255));
            push_byte(b);
          end
        end
      end
      // leave a partial frame for the next mode change
      if ($urandom_range(0, 1) == 1) begin
        push_byte(sfsc_pkg::HEADER_BYTE);
        push_byte(sfsc_pkg::HEADER_BYTE);
        repeat ($urandom_range(0, 12)) begin
          push_byte(8'($urandom_range(0, 255)));
          phase_bytes++;
        end
      end
      random_bytes += phase_bytes;
      wait_idle();
      ph++;
    end

    if (errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("Verification failed");
    $finish;
  end

endmodule
